// ===== src/gpt_pkg.sv =====
// Shared types, constants and codes for the grid point table.
// Holds the beat structs, the operation and sequencer codes and the table sizing.
// No dependencies.
package gpt_pkg;

    // Table sizing and tile size (tile is 1 << TILE_SHIFT pixels square)
    localparam int MAX_ENTRIES = 64;
    localparam int TILE_SHIFT  = 5;

    localparam int POS_W   = 16;
    localparam int CELL_W  = POS_W - TILE_SHIFT;
    localparam int ADDR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    // Half-pixel distances: 2 * centre - 2 * pos needs two bits over a position; DIST_W gives three
    localparam int DIST_W  = POS_W + 3;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_MOVE   = 2'd1,
        OP_FIND   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // Request beat
    typedef struct packed {
        op_t                      operation;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [7:0]               entry_index;
        logic [15:0]              reach;
    } req_t;

    // Response beat
    typedef struct packed {
        logic       ok;
        logic [7:0] slot;
        logic [8:0] entry_count;
    } rsp_t;

    // One stored table entry
    typedef struct packed {
        logic signed [CELL_W-1:0] cx;
        logic signed [CELL_W-1:0] cy;
    } entry_t;

    // Query held for the length of one operation
    typedef struct packed {
        logic signed [CELL_W-1:0] cx;
        logic signed [CELL_W-1:0] cy;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [15:0]              reach;
    } qry_t;

    // Compare unit result
    typedef struct packed {
        logic eq;
        logic near;
    } match_t;

endpackage

// ===== src/gpt_match.sv =====
// Compare unit of the grid point table: tests one stored entry against the query.
// Gives cell equality and the per-axis reach test in half-pixel units.
// Depends on gpt_pkg.
module gpt_match (
    input  gpt_pkg::entry_t entry,
    input  gpt_pkg::qry_t   qry,
    output gpt_pkg::match_t hit
);
    import gpt_pkg::*;

    localparam logic signed [DIST_W-1:0] TILE_D = DIST_W'(1 << TILE_SHIFT);

    logic signed [DIST_W-1:0] cen_x;
    logic signed [DIST_W-1:0] cen_y;
    logic signed [DIST_W-1:0] dx;
    logic signed [DIST_W-1:0] dy;
    logic [DIST_W-1:0]        mag_x;
    logic [DIST_W-1:0]        mag_y;
    logic [DIST_W-1:0]        lim;

    // Doubled cell centre minus doubled point, then magnitude against doubled reach
    always_comb
    begin
        cen_x = (DIST_W'(entry.cx) <<< (TILE_SHIFT + 1)) + TILE_D;
        cen_y = (DIST_W'(entry.cy) <<< (TILE_SHIFT + 1)) + TILE_D;
        dx    = cen_x - (DIST_W'(qry.pos_x) <<< 1);
        dy    = cen_y - (DIST_W'(qry.pos_y) <<< 1);
        mag_x = dx[DIST_W-1] ? unsigned'(-dx) : unsigned'(dx);
        mag_y = dy[DIST_W-1] ? unsigned'(-dy) : unsigned'(dy);
        lim   = DIST_W'({qry.reach, 1'b0});
    end

    assign hit.eq   = (entry.cx == qry.cx) && (entry.cy == qry.cy);
    assign hit.near = (mag_x <= lim) && (mag_y <= lim);

endmodule

// ===== src/grid_point_table.sv =====
// Grid point table top level: sequencer, entry memory and result register.
// Depends on gpt_pkg and gpt_match.
//
// The block holds up to MAX_ENTRIES grid cells in a one-read, one-write entry memory and
// serves one request at a time; req_stall stays high from acceptance until the response
// beat is taken. Add, move, find and remove all scan the table in slot order through the
// single memory read port and one shared compare unit, one entry per cycle, stopping at
// the first hit. The scan issues each read while comparing the entry read before it, and
// closes once a hit is seen or every stored entry has been read and compared. Remove then
// compacts the table, moving each entry above the removed slot down one slot per cycle,
// and then enters the response state. An add to a full table or a move with an index out
// of range answers in the cycle after acceptance, with no scan. After the response beat
// is taken the block returns to idle before it can accept the next request. Entries are
// never cleared after reset; no slot beyond the count is ever compared or moved, though
// the read port may read one.
module grid_point_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  gpt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output gpt_pkg::rsp_t rsp
);
    import gpt_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    issue_reg;
    logic [CNT_W-1:0]    issue_next;
    logic                pend_reg;
    logic                pend_next;
    logic [ADDR_W-1:0]   pend_idx_reg;
    logic [ADDR_W-1:0]   pend_idx_next;
    qry_t                qry_reg;
    qry_t                qry_next;
    op_t                 op_reg;
    op_t                 op_next;
    logic [7:0]          idx_reg;
    logic [7:0]          idx_next;
    logic                ok_reg;
    logic                ok_next;
    logic [ADDR_W-1:0]   slot_reg;
    logic [ADDR_W-1:0]   slot_next;
    entry_t              rdata_reg;

    entry_t              mem [MAX_ENTRIES];
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    entry_t              wr_data;
    logic [ADDR_W-1:0]   rd_addr;

    match_t              match;
    logic                accept;
    logic                early_fail;
    logic                cmp_eq;
    logic                skip;
    logic                hit_now;
    logic                more;
    logic                scan_end;
    logic                shift_end;

    // Shared compare unit sees the entry read last cycle
    gpt_match u_match (
        .entry (rdata_reg),
        .qry   (qry_reg),
        .hit   (match)
    );

    // Scan and compaction status
    always_comb
    begin
        accept     = req_valid && (state_reg == ST_IDLE);
        early_fail = ((req.operation == OP_ADD) && (9'(count_reg) == 9'(MAX_ENTRIES)))
                  || ((req.operation == OP_MOVE) && ({1'b0, req.entry_index} >= 9'(count_reg)));
        cmp_eq     = (op_reg == OP_ADD) || (op_reg == OP_MOVE);
        skip       = (op_reg == OP_MOVE) && (8'(pend_idx_reg) == idx_reg);
        hit_now    = pend_reg && (cmp_eq ? (match.eq && !skip) : match.near);
        more       = issue_reg < count_reg;
        scan_end   = hit_now || (!more && !pend_reg);
        shift_end  = !more && !pend_reg;
        rd_addr    = issue_reg[ADDR_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = early_fail ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (hit_now && (op_reg == OP_REMOVE)) ? ST_SHIFT : ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (shift_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        qry_next      = qry_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        ok_next       = ok_reg;
        slot_next     = slot_reg;
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg - ADDR_W'(1);
        wr_data       = rdata_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // Capture the request and snap the point to its cell
                if (accept)
                begin
                    qry_next.cx    = CELL_W'(req.pos_x >>> TILE_SHIFT);
                    qry_next.cy    = CELL_W'(req.pos_y >>> TILE_SHIFT);
                    qry_next.pos_x = req.pos_x;
                    qry_next.pos_y = req.pos_y;
                    qry_next.reach = req.reach;
                    op_next        = req.operation;
                    idx_next       = req.entry_index;
                    issue_next     = '0;
                    ok_next        = 1'b0;
                    slot_next      = '0;
                end
            end
            ST_SCAN:
            begin
                // Issue the next read while comparing the previous one
                if (more)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_addr;
                    issue_next    = issue_reg + CNT_W'(1);
                end
                if (scan_end)
                begin
                    pend_next = 1'b0;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (!hit_now)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[ADDR_W-1:0];
                                wr_data    = '{cx: qry_reg.cx, cy: qry_reg.cy};
                                ok_next    = 1'b1;
                                slot_next  = count_reg[ADDR_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_MOVE:
                        begin
                            if (!hit_now)
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = idx_reg[ADDR_W-1:0];
                                wr_data   = '{cx: qry_reg.cx, cy: qry_reg.cy};
                                ok_next   = 1'b1;
                                slot_next = idx_reg[ADDR_W-1:0];
                            end
                        end
                        OP_FIND:
                        begin
                            ok_next   = hit_now;
                            slot_next = hit_now ? pend_idx_reg : '0;
                        end
                        OP_REMOVE:
                        begin
                            ok_next   = hit_now;
                            slot_next = hit_now ? pend_idx_reg : '0;
                            // Start compaction at the entry above the hit
                            issue_next = CNT_W'(pend_idx_reg) + CNT_W'(1);
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                // Move each later entry down one slot
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                end
                if (more)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_addr;
                    issue_next    = issue_reg + CNT_W'(1);
                end
                if (shift_end)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                pend_next = 1'b0;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        qry_reg      <= qry_next;
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        ok_reg       <= ok_next;
        slot_reg     <= slot_next;
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Handshake and response beat
    assign req_stall       = (state_reg != ST_IDLE);
    assign rsp_valid       = (state_reg == ST_DONE);
    assign rsp.ok          = ok_reg;
    assign rsp.slot        = 8'(slot_reg);
    assign rsp.entry_count = 9'(count_reg);

endmodule

// ===== sim/grid_point_table_tb.sv =====
// Self-checking testbench for grid_point_table: directed and random request beats,
// a request-level table predictor, and response checking with random idling on both channels.
// Depends on gpt_pkg and the grid_point_table RTL.
`timescale 1ns / 1ps

module grid_point_table_tb;

    import gpt_pkg::*;

    // Cycles with no beat on either channel before the run is abandoned
    localparam int QUIET_LIMIT = 4000;
    // Stretch of beats with no idling on either side
    localparam int CALM_FIRST  = 400;
    localparam int CALM_LAST   = 600;
    localparam int MAX_REPORTS = 10;
    localparam int TILE        = 1 << TILE_SHIFT;
    // Region of cells the random phases draw from, per axis
    localparam int REGION_CELLS = 12;
    localparam int CELL_MIN     = -(1 << (CELL_W - 1));
    localparam int CELL_MAX     = (1 << (CELL_W - 1)) - 1;

    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } mix_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    rsp_t want_rsp;

    // Predicted table contents
    int   tbl_count;
    int   tbl_cx [MAX_ENTRIES];
    int   tbl_cy [MAX_ENTRIES];

    int   reqs_taken   = 0;
    int   rsps_seen    = 0;
    int   fail_count   = 0;
    int   quiet_cycles = 0;

    grid_point_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor of a pixel position over the tile size
    function automatic int cell_of(logic signed [POS_W-1:0] p);
        int v;
        v = $signed(p);
        return v >>> TILE_SHIFT;
    endfunction

    // True when a slot other than skip holds cell (cx, cy); skip of -1 checks all
    function automatic bit cell_taken(int cx, int cy, int skip);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (i != skip && tbl_cx[i] == cx && tbl_cy[i] == cy)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Compare in half pixels so that centres on half pixels stay exact
    function automatic bit point_near(int i, int px, int py, int rch);
        int dx;
        int dy;
        dx = 2 * tbl_cx[i] * TILE + TILE - 2 * px;
        dy = 2 * tbl_cy[i] * TILE + TILE - 2 * py;
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        return (dx <= 2 * rch) && (dy <= 2 * rch);
    endfunction

    // Apply one request to the predicted table and return the response it yields
    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        int   cx;
        int   cy;
        int   px;
        int   py;
        int   idx;
        int   rch;
        int   hit;
        res = '0;
        px  = $signed(r.pos_x);
        py  = $signed(r.pos_y);
        idx = r.entry_index;
        rch = r.reach;
        cx  = cell_of(r.pos_x);
        cy  = cell_of(r.pos_y);
        hit = -1;
        case (r.operation)
            OP_ADD:
            begin
                if (tbl_count < MAX_ENTRIES && !cell_taken(cx, cy, -1))
                begin
                    tbl_cx[tbl_count] = cx;
                    tbl_cy[tbl_count] = cy;
                    res.ok   = 1'b1;
                    res.slot = 8'(tbl_count);
                    tbl_count++;
                end
            end
            OP_MOVE:
            begin
                if (idx < tbl_count && !cell_taken(cx, cy, idx))
                begin
                    tbl_cx[idx] = cx;
                    tbl_cy[idx] = cy;
                    res.ok   = 1'b1;
                    res.slot = 8'(idx);
                end
            end
            default:
            begin
                for (int i = 0; i < tbl_count && hit < 0; i++)
                begin
                    if (point_near(i, px, py, rch))
                        hit = i;
                end
                if (hit >= 0)
                begin
                    res.ok   = 1'b1;
                    res.slot = 8'(hit);
                    // Compact: shift the later entries down one slot
                    if (r.operation == OP_REMOVE)
                    begin
                        for (int i = hit; i + 1 < tbl_count; i++)
                        begin
                            tbl_cx[i] = tbl_cx[i + 1];
                            tbl_cy[i] = tbl_cy[i + 1];
                        end
                        tbl_count--;
                    end
                end
            end
        endcase
        res.entry_count = 9'(tbl_count);
        return res;
    endfunction

    function automatic bit take_break(int beats_done);
        if (beats_done >= CALM_FIRST && beats_done < CALM_LAST)
            return 1'b0;
        return $urandom_range(0, 99) < 14;
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic queue_req(op_t op, int x, int y, int idx, int rch);
        req_t r;
        r.operation   = op;
        r.pos_x       = 16'(x);
        r.pos_y       = 16'(y);
        r.entry_index = 8'(idx);
        r.reach       = 16'(rch);
        pending_reqs.push_back(r);
    endtask

    // Pick a region corner: often at the edges of the coordinate range
    function automatic int region_base();
        case ($urandom_range(0, 3))
            0:       return CELL_MIN;
            1:       return CELL_MAX - REGION_CELLS + 1;
            default: return int'($urandom_range(0, CELL_MAX - CELL_MIN - REGION_CELLS + 1))
                            + CELL_MIN;
        endcase
    endfunction

    // Random phase: points within a small region of cells so adds collide and finds hit
    task automatic queue_phase(mix_t mix, int n_items);
        int bx;
        int by;
        int roll;
        int x;
        int y;
        int rch;
        op_t op;
        bx = region_base();
        by = region_base();
        for (int n = 0; n < n_items; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                // Noise beat: every field fully random
                queue_req(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:
                        op = roll < 75 ? OP_ADD : roll < 85 ? OP_MOVE :
                             roll < 95 ? OP_FIND : OP_REMOVE;
                    MIX_BALANCED:
                        op = roll < 30 ? OP_ADD : roll < 55 ? OP_MOVE :
                             roll < 80 ? OP_FIND : OP_REMOVE;
                    default:
                        op = roll < 10 ? OP_ADD : roll < 20 ? OP_MOVE :
                             roll < 40 ? OP_FIND : OP_REMOVE;
                endcase
                x = (bx + int'($urandom_range(0, REGION_CELLS - 1))) * TILE
                    + int'($urandom_range(0, TILE - 1));
                y = (by + int'($urandom_range(0, REGION_CELLS - 1))) * TILE
                    + int'($urandom_range(0, TILE - 1));
                if (mix == MIX_DRAIN)
                    rch = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 400);
                else
                    rch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 48);
                queue_req(op, x, y, $urandom_range(0, MAX_ENTRIES + 5), rch);
            end
        end
    endtask

    // Driver: present queued request beats, hold while stalled, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(apply_request(req));
                reqs_taken++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 && !take_break(reqs_taken))
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random, check each response beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                    note_failure($sformatf("unexpected response ok=%0d slot=%0d count=%0d",
                                           rsp.ok, rsp.slot, rsp.entry_count));
                else
                begin
                    want_rsp = expected_rsps.pop_front();
                    if (rsp.ok !== want_rsp.ok || rsp.slot !== want_rsp.slot ||
                        rsp.entry_count !== want_rsp.entry_count)
                        note_failure($sformatf(
                            "response %0d: expected ok=%0d slot=%0d count=%0d, got ok=%0d slot=%0d count=%0d",
                            rsps_seen, want_rsp.ok, want_rsp.slot, want_rsp.entry_count,
                            rsp.ok, rsp.slot, rsp.entry_count));
                end
                rsps_seen++;
            end
            rsp_stall <= take_break(rsps_seen);
        end
    end

    // Count cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        tbl_count = 0;

        // Empty table: nothing to find or remove, any move index is out of range
        queue_req(OP_FIND,   0, 0, 0, 65535);
        queue_req(OP_REMOVE, 0, 0, 0, 65535);
        queue_req(OP_MOVE,   0, 0, 0, 0);
        // Corner cells, then the same cell again from another pixel
        queue_req(OP_ADD,    -32768, -32768, 0, 0);
        queue_req(OP_ADD,     32767,  32767, 0, 0);
        queue_req(OP_ADD,    -32768, -32768, 0, 0);
        queue_req(OP_ADD,    -32737, -32768, 0, 0);
        queue_req(OP_ADD,     0,  0, 0, 0);
        queue_req(OP_ADD,    -1, -1, 0, 0);
        // Move onto its own cell, onto another slot's cell, and out of range
        queue_req(OP_MOVE,    32767, 32767, 1, 0);
        queue_req(OP_MOVE,    0, 5, 1, 0);
        queue_req(OP_MOVE,    0, 0, 4, 0);
        queue_req(OP_MOVE,    0, 0, 255, 0);
        // Zero reach hits only the exact centre; a pixel off misses
        queue_req(OP_FIND,    16, 16, 0, 0);
        queue_req(OP_FIND,    15, 16, 0, 0);
        queue_req(OP_FIND,   -16, -16, 0, 0);
        queue_req(OP_FIND,    0, 0, 0, 65535);
        // Remove the first slot, miss, then remove the shifted-down corner entry
        queue_req(OP_REMOVE,  32767, 32767, 0, 65535);
        queue_req(OP_REMOVE,  100, 100, 0, 0);
        queue_req(OP_REMOVE,  32752, 32752, 0, 0);
        queue_req(OP_FIND,   -32768, 32767, 0, 65535);
        queue_req(OP_MOVE,    1000, -1000, 0, 0);

        for (int p = 0; p < 6; p++)
            queue_phase(mix_t'(p % 3), 165);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all beats sent and every prediction answered
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(negedge clk);
        repeat (2 * MAX_ENTRIES + 8) @(posedge clk);
        @(negedge clk);

        if (expected_rsps.size() != 0)
            note_failure($sformatf("%0d responses never arrived", expected_rsps.size()));

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
